@@ src/str_pkg.sv @@
package str_pkg;

    localparam int OP_BITS = 1;
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;        // latch and sort vertices
        logic div_start;   // start both edge divisions for current row
        logic row_load;    // take division results as span bounds
        logic advance;     // emit pending pixel and advance
        logic emit_idle;   // emit an all-zero result
    } str_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic row_change;  // advancing ends the span and needs new bounds
        logic finish;      // advancing ends the triangle
    } str_status_t;

endpackage

@@ src/str_divider.sv @@
module str_divider #(
    parameter int W = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [W:0]    trial;
    logic [W-1:0]  rem_shift;

    // restoring division, one quotient bit per cycle, unsigned operands
    assign rem_shift = {rem_reg[W-2:0], quo_reg[W-1]};
    assign trial = {1'b0, rem_shift} - {1'b0, den_reg};
    assign done = !busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end
endmodule

@@ src/str_edge.sv @@
module str_edge #(
    parameter int CB = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [CB-1:0] ax,
    input  logic [CB-1:0] ay,
    input  logic [CB-1:0] bx,
    input  logic [CB-1:0] by,
    input  logic [CB-1:0] row,
    output logic          done,
    output logic [CB-1:0] x
);
    localparam int PW = 2 * CB + 2;

    logic signed [CB:0]   dy;
    logic signed [CB:0]   dx;
    logic signed [CB:0]   dr;
    logic signed [PW-1:0] prod_reg;
    logic signed [CB:0]   den_reg;
    logic [CB-1:0]        ax_reg;
    logic                 flat_reg;
    logic                 neg_reg;
    logic                 mul_reg;
    logic [PW-1:0]        num_abs;
    logic [PW-1:0]        den_abs;
    logic                 div_done;
    logic [PW-1:0]        quo;
    logic [PW-1:0]        sq;

    assign dy = $signed({1'b0, by}) - $signed({1'b0, ay});
    assign dx = $signed({1'b0, bx}) - $signed({1'b0, ax});
    assign dr = $signed({1'b0, row}) - $signed({1'b0, ay});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg <= 1'b0;
        end
        else
        begin
            mul_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PW'(dr * dx);
            den_reg  <= dy;
            ax_reg   <= ax;
            flat_reg <= (ay == by);
        end
        if (mul_reg)
        begin
            neg_reg <= prod_reg[PW-1] ^ den_reg[CB];
        end
    end

    assign num_abs = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
    assign den_abs = den_reg[CB] ? PW'(-den_reg) : PW'(den_reg);

    str_divider #(.W(PW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_reg),
        .dividend (num_abs),
        .divisor  (den_abs),
        .done     (div_done),
        .quotient (quo)
    );

    assign sq = neg_reg ? -quo : quo;
    assign done = div_done && !mul_reg && !start;
    assign x = flat_reg ? ax_reg : ax_reg + sq[CB-1:0];
endmodule

@@ src/str_datapath.sv @@
module str_datapath #(
    parameter int CB = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  str_pkg::str_cmd_t cmd,
    input  logic [CB-1:0]     vax,
    input  logic [CB-1:0]     vay,
    input  logic [CB-1:0]     vbx,
    input  logic [CB-1:0]     vby,
    input  logic [CB-1:0]     vcx,
    input  logic [CB-1:0]     vcy,
    output str_pkg::str_status_t sts,
    output logic              res_valid,
    output logic [CB-1:0]     res_x,
    output logic [CB-1:0]     res_y,
    output logic              res_last
);
    import str_pkg::*;

    logic [CB-1:0] v_reg [6];
    logic [CB-1:0] cur_x_reg;
    logic [CB-1:0] row_reg;
    logic [CB-1:0] end_x_reg;
    logic          lower_reg;
    logic [CB-1:0] s0x, s0y, s1x, s1y, s2x, s2y;
    logic [CB-1:0] t0x, t0y, t1x, t1y, t2x, t2y;
    logic [CB-1:0] u0x, u0y, u1x, u1y, u2x, u2y;
    logic          long_done, short_done;
    logic          short_lower;
    logic [CB-1:0] long_x, short_x;

    // three compare-and-swap stages, ascending by row
    always_comb
    begin
        {s0x, s0y, s1x, s1y, s2x, s2y} = {vax, vay, vbx, vby, vcx, vcy};
        if (s0y > s1y)
        begin
            {s0x, s0y, s1x, s1y} = {s1x, s1y, s0x, s0y};
        end
        {t0x, t0y, t1x, t1y, t2x, t2y} = {s0x, s0y, s1x, s1y, s2x, s2y};
        if (t0y > t2y)
        begin
            {t0x, t0y, t2x, t2y} = {t2x, t2y, t0x, t0y};
        end
        {u0x, u0y, u1x, u1y, u2x, u2y} = {t0x, t0y, t1x, t1y, t2x, t2y};
        if (u1y > u2y)
        begin
            {u1x, u1y, u2x, u2y} = {u2x, u2y, u1x, u1y};
        end
    end

    assign short_lower = lower_reg;

    str_edge #(.CB(CB)) u_long (
        .clk (clk), .rst_n (rst_n), .start (cmd.div_start),
        .ax (v_reg[0]), .ay (v_reg[1]), .bx (v_reg[4]), .by (v_reg[5]),
        .row (row_reg), .done (long_done), .x (long_x)
    );

    str_edge #(.CB(CB)) u_short (
        .clk (clk), .rst_n (rst_n), .start (cmd.div_start),
        .ax (short_lower ? v_reg[2] : v_reg[0]),
        .ay (short_lower ? v_reg[3] : v_reg[1]),
        .bx (short_lower ? v_reg[4] : v_reg[2]),
        .by (short_lower ? v_reg[5] : v_reg[3]),
        .row (row_reg), .done (short_done), .x (short_x)
    );

    assign sts.div_done   = long_done && short_done;
    assign sts.row_change = (cur_x_reg == end_x_reg) &&
                            (!lower_reg || row_reg < v_reg[5]);
    assign sts.finish     = (cur_x_reg == end_x_reg) && lower_reg &&
                            !(row_reg < v_reg[5]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                v_reg[i] <= '0;
            end
            cur_x_reg <= '0;
            row_reg   <= '0;
            end_x_reg <= '0;
            lower_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            v_reg[0]  <= u0x;
            v_reg[1]  <= u0y;
            v_reg[2]  <= u1x;
            v_reg[3]  <= u1y;
            v_reg[4]  <= u2x;
            v_reg[5]  <= u2y;
            row_reg   <= u0y;
            lower_reg <= 1'b0;
        end
        else if (cmd.row_load)
        begin
            cur_x_reg <= long_x;
            end_x_reg <= short_x;
        end
        else if (cmd.advance)
        begin
            if (cur_x_reg != end_x_reg)
            begin
                cur_x_reg <= (cur_x_reg < end_x_reg) ? cur_x_reg + 1'b1
                                                     : cur_x_reg - 1'b1;
            end
            else if (!lower_reg)
            begin
                if (row_reg < v_reg[3])
                begin
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    lower_reg <= 1'b1;
                    row_reg   <= v_reg[3];
                end
            end
            else if (row_reg < v_reg[5])
            begin
                row_reg <= row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.advance)
        begin
            res_valid <= 1'b1;
            res_x     <= cur_x_reg;
            res_y     <= row_reg;
            res_last  <= sts.finish;
        end
        else if (cmd.emit_idle)
        begin
            res_valid <= 1'b0;
            res_x     <= '0;
            res_y     <= '0;
            res_last  <= 1'b0;
        end
    end
endmodule

@@ src/str_control.sv @@
module str_control (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_op,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  str_pkg::str_status_t sts,
    output str_pkg::str_cmd_t    cmd
);
    import str_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_WAIT, S_STEP, S_OUT
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   first_reg;
    logic   out_valid_reg;
    logic   accept;
    logic   out_free;
    logic   out_set;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    // every advance or idle reply loads the result register
    assign out_set   = cmd.advance || cmd.emit_idle;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load      = accept && (in_op == OP_START);
                cmd.emit_idle = accept && (in_op == OP_STEP) && !busy_reg;
            end
            S_DIV:  cmd.div_start = 1'b1;
            S_WAIT: cmd.row_load  = sts.div_done;
            S_STEP: cmd.advance   = out_free;
            S_OUT:  ;
            default: ;
        endcase
        if (state_reg == S_IDLE && accept && in_op == OP_STEP && busy_reg)
        begin
            cmd.advance = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_set || (out_valid_reg && !out_ready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.load)
                    begin
                        busy_reg  <= 1'b1;
                        first_reg <= 1'b1;
                        state_reg <= S_DIV;
                    end
                    else if (cmd.advance)
                    begin
                        if (sts.finish)
                        begin
                            busy_reg <= 1'b0;
                        end
                        if (sts.row_change)
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:  state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (sts.div_done)
                    begin
                        // the first pixel of a triangle still owes its result
                        state_reg <= first_reg ? S_OUT : S_IDLE;
                    end
                end
                S_OUT:  state_reg <= S_STEP;
                S_STEP:
                begin
                    if (out_free)
                    begin
                        first_reg <= 1'b0;
                        if (sts.finish)
                        begin
                            busy_reg <= 1'b0;
                        end
                        state_reg <= sts.row_change ? S_DIV : S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ src/scanline_triangle_rasterizer.sv @@
// channel   | dir | tdata (low bit up)                     | tuser       | tlast
// s_axis    | in  | vertex_a_x..vertex_c_y, COORD_BITS each | operation   | -
// m_axis    | out | pixel_x, pixel_y                       | pixel_valid | last_pixel
//
// a start request gives its pixel once both edge divisions are done
// (the divisions run side by side, one quotient bit per cycle)
// a step request within a row answers on the next cycle, and the next request
// can be taken then; a row-opening one holds the input while the divisions run
// reset clears the control and vertex state; the block is idle and empty after reset
// a stalled output holds its result and blocks the next request
module scanline_triangle_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,   // a_x, a_y, b_x, b_y, c_x, c_y
    input  logic                                   s_axis_tuser,   // operation
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,   // pixel_x, pixel_y
    output logic                                   m_axis_tuser,   // pixel_valid
    output logic                                   m_axis_tlast    // last_pixel
);
    import str_pkg::*;

    localparam int TDI_W = ((6 * COORD_BITS + 7) / 8) * 8;
    localparam int TDO_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int CB = COORD_BITS;

    str_cmd_t      cmd;
    str_status_t   sts;
    logic          res_valid, res_last;
    logic [CB-1:0] res_x, res_y;

    // control sequencing: start, row setup, pixel stepping
    str_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_op     (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // vertex sort, edge interpolation and span walk
    str_datapath #(.CB(CB)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .vax       (s_axis_tdata[0*CB +: CB]),
        .vay       (s_axis_tdata[1*CB +: CB]),
        .vbx       (s_axis_tdata[2*CB +: CB]),
        .vby       (s_axis_tdata[3*CB +: CB]),
        .vcx       (s_axis_tdata[4*CB +: CB]),
        .vcy       (s_axis_tdata[5*CB +: CB]),
        .sts       (sts),
        .res_valid (res_valid),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_last  (res_last)
    );

    assign m_axis_tdata = TDO_W'({res_y, res_x});
    assign m_axis_tuser = res_valid;
    assign m_axis_tlast = res_last;

`ifndef SYNTHESIS
    // no request is taken while a result waits unread
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("request taken over a pending result");
    // a start request always runs the edge divisions before the next request
    a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_START) |=> !s_axis_tready)
        else $error("request taken during triangle setup");
    // last pixel always carries a valid pixel
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("last flag without pixel");
`endif
endmodule
